// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue store
// Holds the depth and width constants, the operation and status codes, and
// the control and probe bundles that the top level hands to each cell.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int STAT_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_SEARCH     = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

  // One operation per cycle at most; every cell sees the same bundle.
  typedef struct packed {
    logic                  clear;
    logic                  shift_right;
    logic                  shift_left;
    logic                  write_back;
    logic                  drop_back;
    logic                  flush_probe;
    logic [DATA_WIDTH-1:0] push_data;
  } cell_ctrl_t;

  // Search probe that travels one cell per cycle toward the back.
  typedef struct packed {
    logic                  tok;
    logic [DATA_WIDTH-1:0] key;
  } probe_t;

endpackage

// ===== hdl/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell: one slot of the queue chain
// Holds one entry and its occupancy bit, shifts with its neighbors on front
// pushes and pops, and compares a passing search probe against its entry.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  deq_pkg::cell_ctrl_t              ctrl,
  input  logic [deq_pkg::DATA_WIDTH-1:0]   left_data_i,
  input  logic                             left_valid_i,
  input  logic [deq_pkg::DATA_WIDTH-1:0]   right_data_i,
  input  logic                             right_valid_i,
  input  deq_pkg::probe_t                  probe_i,
  output logic [deq_pkg::DATA_WIDTH-1:0]   data_o,
  output logic                             valid_o,
  output deq_pkg::probe_t                  probe_o,
  output logic [deq_pkg::DATA_WIDTH-1:0]   tail_data_o,
  output logic                             hit_o,
  output logic                             end_o
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic                  valid_r;
  logic                  tok_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic                  is_tail;
  logic                  is_first_free;

  assign is_tail       = valid_r & ~right_valid_i;
  assign is_first_free = ~valid_r & left_valid_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      priority if (ctrl.clear) begin
        valid_r <= 1'b0;
      end else if (ctrl.shift_right) begin
        valid_r <= left_valid_i;
      end else if (ctrl.shift_left) begin
        valid_r <= right_valid_i;
      end else if (ctrl.write_back && is_first_free) begin
        valid_r <= 1'b1;
      end else if (ctrl.drop_back && is_tail) begin
        valid_r <= 1'b0;
      end else begin
        valid_r <= valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.shift_right) begin
      data_r <= left_data_i;
    end else if (ctrl.shift_left) begin
      data_r <= right_data_i;
    end else if (ctrl.write_back && is_first_free) begin
      data_r <= ctrl.push_data;
    end else begin
      data_r <= data_r;
    end
  end

  // Advance the probe every cycle; drop it once the search has finished.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else if (ctrl.flush_probe) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= probe_i.tok;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= probe_i.key;
  end

  assign data_o      = data_r;
  assign valid_o     = valid_r;
  assign probe_o.tok = tok_r;
  assign probe_o.key = key_r;
  assign tail_data_o = is_tail ? data_r : '0;
  assign hit_o       = tok_r & valid_r & (data_r == key_r);
  assign end_o       = tok_r & ~valid_r;

endmodule

// ===== hdl/double_ended_queue_store.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_store: bounded double-ended queue of signed values
// Push and pop at either end, clear, and search from the front, kept in a
// row of cells with the front entry always in the first cell.
// ----------------------------------------------------------------------------
// Usage: raise start with in_operation and in_value; the item transfers when
// start is high and busy is low. Every item returns one result on the out_
// ports, flagged by out_valid for exactly one cycle; the receiver cannot hold
// it off. Push, pop, clear and unknown codes leave busy low, and a new item
// can transfer on the very next cycle, with its result shown the cycle after
// it transfers. A search sends a probe down the cell chain one cell per cycle
// and holds busy high until the first match or the end of the held entries,
// never past the last of the DEPTH cells (16 here).
// ----------------------------------------------------------------------------
module double_ended_queue_store (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [deq_pkg::OP_W-1:0]              in_operation,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0] in_value,
  output logic                                  out_valid,
  output logic [deq_pkg::STAT_W-1:0]            out_status,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] out_popped_value,
  output logic [deq_pkg::IDX_W-1:0]             out_position,
  output logic [deq_pkg::CNT_W-1:0]             out_count
);
  import deq_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic                  out_valid_r;
  status_t               status_r;
  logic [DATA_WIDTH-1:0] popped_r;
  logic [IDX_W-1:0]      position_r;
  logic [CNT_W-1:0]      count_r;

  cell_ctrl_t            ctrl;
  probe_t                probe_in;
  logic                  accept;
  logic                  res_fire;
  status_t               res_status;
  logic [DATA_WIDTH-1:0] res_popped;
  logic [IDX_W-1:0]      res_pos;
  logic                  is_full;
  logic                  is_empty;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail  [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_hit;
  logic [DEPTH-1:0]      cell_end;
  probe_t                cell_probe [DEPTH];
  logic [DATA_WIDTH-1:0] tail_data;
  logic                  any_hit;
  logic                  any_end;

  assign busy     = (state_r == S_SEARCH);
  assign accept   = start & ~busy;
  assign is_full  = (cnt_r == CNT_W'(DEPTH));
  assign is_empty = (cnt_r == '0);

  assign probe_in.tok = accept & (op_t'(in_operation) == OP_SEARCH);
  assign probe_in.key = in_value;

  // ---- cell chain ----
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] ld, rd;
    logic                  lv, rv;
    probe_t                pin;
    if (g == 0) begin : g_head
      assign ld  = in_value;
      assign lv  = 1'b1;
      assign pin = probe_in;
    end else begin : g_mid
      assign ld  = cell_data[g-1];
      assign lv  = cell_valid[g-1];
      assign pin = cell_probe[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rd = '0;
      assign rv = 1'b0;
    end else begin : g_body
      assign rd = cell_data[g+1];
      assign rv = cell_valid[g+1];
    end
    deq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .left_data_i  (ld),
      .left_valid_i (lv),
      .right_data_i (rd),
      .right_valid_i(rv),
      .probe_i      (pin),
      .data_o       (cell_data[g]),
      .valid_o      (cell_valid[g]),
      .probe_o      (cell_probe[g]),
      .tail_data_o  (cell_tail[g]),
      .hit_o        (cell_hit[g]),
      .end_o        (cell_end[g])
    );
  end

  assign any_hit = |cell_hit;
  assign any_end = |cell_end;

  // Only the tail cell drives nonzero data.
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | cell_tail[i];
    end
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && op_t'(in_operation) == OP_SEARCH) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (any_hit || any_end || pos_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- outputs and datapath control ----
  always_comb begin
    ctrl           = '0;
    ctrl.push_data = in_value;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    res_fire       = 1'b0;
    res_status     = ST_OK;
    res_popped     = '0;
    res_pos        = '0;
    unique case (state_r)
      S_IDLE: begin
        pos_nxt = '0;
        if (accept) begin
          res_fire = 1'b1;
          unique case (op_t'(in_operation))
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.shift_right = 1'b1;
                cnt_nxt          = cnt_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.write_back = 1'b1;
                cnt_nxt         = cnt_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctrl.shift_left = 1'b1;
                res_popped      = cell_data[0];
                cnt_nxt         = cnt_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctrl.drop_back = 1'b1;
                res_popped     = tail_data;
                cnt_nxt        = cnt_r - 1'b1;
              end
            end
            OP_CLEAR: begin
              ctrl.clear = 1'b1;
              cnt_nxt    = '0;
            end
            OP_SEARCH: begin
              res_fire = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        priority if (any_hit) begin
          res_fire         = 1'b1;
          res_pos          = pos_r;
          ctrl.flush_probe = 1'b1;
        end else if (any_end || pos_r == IDX_W'(DEPTH - 1)) begin
          res_fire         = 1'b1;
          res_status       = ST_NOT_FOUND;
          ctrl.flush_probe = 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= res_fire;
    end
  end

  // Hold the last result; the strobe marks the single transfer cycle.
  always_ff @(posedge clk) begin
    if (res_fire) begin
      status_r   <= res_status;
      popped_r   <= res_popped;
      position_r <= res_pos;
      count_r    <= cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_position     = position_r;
  assign out_count        = count_r;

endmodule

// ===== hdl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue store
// Watches the command and result ports and flags timing or range slips.
// ----------------------------------------------------------------------------
module deq_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [deq_pkg::OP_W-1:0]              in_operation,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0] in_value,
  input  logic                                  out_valid,
  input  logic [deq_pkg::STAT_W-1:0]            out_status,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0] out_popped_value,
  input  logic [deq_pkg::IDX_W-1:0]             out_position,
  input  logic [deq_pkg::CNT_W-1:0]             out_count
);
  import deq_pkg::*;

  // A result never shows while a search is still walking.
  a_no_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Every non-search transfer returns its result on the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_SEARCH) |=> out_valid)
    else $error("missing result after one-cycle operation");

  // A search transfer makes the block busy on the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_SEARCH) |=> (busy && !out_valid))
    else $error("search did not start");

  // The reported count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(DEPTH)))
    else $error("count out of range");

  // A pop that reports empty returns zero and an empty count.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_popped_value == '0 && out_count == '0))
    else $error("bad empty pop result");

endmodule

bind double_ended_queue_store deq_checker u_deq_checker (.*);
